@@ rtl/sip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

  // Coordinate format: signed, 8 fraction bits
  localparam int COORD_W        = 24;
  localparam int RATIO_BITS_DEF = 16;

  // Coordinate differences, cross products, determinants, magnitudes
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * COORD_W + 1;
  localparam int Z_W    = 2 * COORD_W + 2;
  localparam int MAG_W  = 2 * COORD_W + 1;
  localparam int DEN_W  = 2 * COORD_W + 2;

  // Queue between front and back
  localparam int MID_DEPTH = 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic             hit;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
    coord_t           bsx;
    coord_t           bsy;
    coord_t           bex;
    coord_t           bey;
  } mid_item_t;

endpackage

`default_nettype wire

@@ rtl/sip_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // Caller guarantees no push when full (credit tracked upstream)
  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign empty = (cnt == '0);
  assign rdata = mem[rptr];

endmodule

`default_nettype wire

@@ rtl/sip_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sip_front
  import sip_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  item,
  input  wire logic      mid_pop,
  output logic           mid_push,
  output mid_item_t      mid_data
);

  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [Z_W-1:0]    det_t;

  logic             accept;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // Stage 1: differences
  logic  v1;
  diff_t dax, day, dbx, dby;
  diff_t u1x, u1y, u2x, u2y, u3x, u3y, u4x, u4y;
  coord_t bsx1, bsy1, bex1, bey1;

  // Stage 2: cross products
  logic  v2;
  prod_t p1a, p1b, p2a, p2b, p3a, p3b, p4a, p4b;
  coord_t bsx2, bsy2, bex2, bey2;

  // Stage 3: determinants
  logic  v3;
  det_t  z1, z2, z3, z4;
  coord_t bsx3, bsy3, bex3, bey3;

  // Stage 4: classification and magnitudes
  logic             v4;
  logic             hit4;
  logic [MAG_W-1:0] mag1, mag2;
  coord_t           bsx4, bsy4, bex4, bey4;

  det_t  abs1, abs2;
  logic  same12, same34;

  assign accept = push && !full;
  assign full   = (cnt == CNT_W'(MID_DEPTH));

  // Credit count: requests in the front pipe plus in the queue
  always_comb begin
    cnt_next = cnt;
    if (accept && !mid_pop) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (mid_pop && !accept) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      v1  <= accept;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dax  <= DIFF_W'(item.a_end_x) - DIFF_W'(item.a_start_x);
    day  <= DIFF_W'(item.a_end_y) - DIFF_W'(item.a_start_y);
    dbx  <= DIFF_W'(item.b_end_x) - DIFF_W'(item.b_start_x);
    dby  <= DIFF_W'(item.b_end_y) - DIFF_W'(item.b_start_y);
    u1x  <= DIFF_W'(item.b_start_x) - DIFF_W'(item.a_start_x);
    u1y  <= DIFF_W'(item.b_start_y) - DIFF_W'(item.a_start_y);
    u2x  <= DIFF_W'(item.b_end_x) - DIFF_W'(item.a_start_x);
    u2y  <= DIFF_W'(item.b_end_y) - DIFF_W'(item.a_start_y);
    u3x  <= DIFF_W'(item.a_start_x) - DIFF_W'(item.b_start_x);
    u3y  <= DIFF_W'(item.a_start_y) - DIFF_W'(item.b_start_y);
    u4x  <= DIFF_W'(item.a_end_x) - DIFF_W'(item.b_start_x);
    u4y  <= DIFF_W'(item.a_end_y) - DIFF_W'(item.b_start_y);
    bsx1 <= item.b_start_x;
    bsy1 <= item.b_start_y;
    bex1 <= item.b_end_x;
    bey1 <= item.b_end_y;
  end

  // Products of two differences always fit PROD_W bits
  always_ff @(posedge clk) begin
    p1a  <= PROD_W'(dax * u1y);
    p1b  <= PROD_W'(day * u1x);
    p2a  <= PROD_W'(dax * u2y);
    p2b  <= PROD_W'(day * u2x);
    p3a  <= PROD_W'(dbx * u3y);
    p3b  <= PROD_W'(dby * u3x);
    p4a  <= PROD_W'(dbx * u4y);
    p4b  <= PROD_W'(dby * u4x);
    bsx2 <= bsx1;
    bsy2 <= bsy1;
    bex2 <= bex1;
    bey2 <= bey1;
  end

  always_ff @(posedge clk) begin
    z1   <= Z_W'(p1a) - Z_W'(p1b);
    z2   <= Z_W'(p2a) - Z_W'(p2b);
    z3   <= Z_W'(p3a) - Z_W'(p3b);
    z4   <= Z_W'(p4a) - Z_W'(p4b);
    bsx3 <= bsx2;
    bsy3 <= bsy2;
    bex3 <= bex2;
    bey3 <= bey2;
  end

  // Equal three-way signs (negative, zero, positive) mean no crossing
  always_comb begin
    same12 = (z1[Z_W-1] == z2[Z_W-1]) && ((z1 == '0) == (z2 == '0));
    same34 = (z3[Z_W-1] == z4[Z_W-1]) && ((z3 == '0) == (z4 == '0));
    abs1   = z1[Z_W-1] ? -z1 : z1;
    abs2   = z2[Z_W-1] ? -z2 : z2;
  end

  always_ff @(posedge clk) begin
    hit4 <= !same12 && !same34;
    mag1 <= abs1[MAG_W-1:0];
    mag2 <= abs2[MAG_W-1:0];
    bsx4 <= bsx3;
    bsy4 <= bsy3;
    bex4 <= bex3;
    bey4 <= bey3;
  end

  assign mid_push = v4;

  always_comb begin
    mid_data.hit = hit4;
    mid_data.num = DEN_W'(mag1);
    mid_data.den = DEN_W'(mag1) + DEN_W'(mag2);
    mid_data.bsx = bsx4;
    mid_data.bsy = bsy4;
    mid_data.bex = bex4;
    mid_data.bey = bey4;
  end

endmodule

`default_nettype wire

@@ rtl/sip_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sip_back
  import sip_pkg::*;
#(
  parameter int RATIO_BITS = RATIO_BITS_DEF,
  parameter int OUT_DEPTH  = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      mid_empty,
  input  wire mid_item_t mid_data,
  output logic           mid_pop,
  input  wire logic      out_pop,
  output logic           out_push,
  output out_item_t      out_data
);

  localparam int NSTG  = RATIO_BITS + 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int PW    = DIFF_W + RATIO_BITS + 2;

  typedef struct packed {
    logic                hit;
    logic [DEN_W-1:0]    rem;
    logic [DEN_W-1:0]    den;
    logic [RATIO_BITS:0] q;
    coord_t              bsx;
    coord_t              bsy;
    coord_t              bex;
    coord_t              bey;
  } div_stage_t;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic       dv [NSTG];
  div_stage_t ds [NSTG];

  logic                 mv;
  logic                 mhit;
  logic signed [PW-1:0] prodx, prody;
  coord_t               mbsx, mbsy;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [RATIO_BITS+1:0] tq;
  logic signed [PW-1:0] shx, shy;

  // Credit count: requests in the back pipe plus in the result queue
  assign mid_pop = !mid_empty && (cnt < CNT_W'(OUT_DEPTH));

  always_comb begin
    cnt_next = cnt;
    if (mid_pop && !out_pop) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (out_pop && !mid_pop) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // First quotient bit: num <= den, so it is set only when equal
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    ds[0].hit <= mid_data.hit;
    ds[0].den <= mid_data.den;
    ds[0].bsx <= mid_data.bsx;
    ds[0].bsy <= mid_data.bsy;
    ds[0].bex <= mid_data.bex;
    ds[0].bey <= mid_data.bey;
    if (mid_data.num >= mid_data.den) begin
      ds[0].rem <= mid_data.num - mid_data.den;
      ds[0].q   <= (RATIO_BITS+1)'(1);
    end else begin
      ds[0].rem <= mid_data.num;
      ds[0].q   <= '0;
    end
  end

  // One restoring division step per stage
  for (genvar k = 1; k < NSTG; k++) begin : g_div
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      sh   = {ds[k-1].rem, 1'b0};
      diff = sh - {1'b0, ds[k-1].den};
      ge   = (sh >= {1'b0, ds[k-1].den});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      ds[k].hit <= ds[k-1].hit;
      ds[k].den <= ds[k-1].den;
      ds[k].bsx <= ds[k-1].bsx;
      ds[k].bsy <= ds[k-1].bsy;
      ds[k].bex <= ds[k-1].bex;
      ds[k].bey <= ds[k-1].bey;
      ds[k].rem <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      ds[k].q   <= {ds[k-1].q[RATIO_BITS-1:0], ge};
    end
  end

  // Interpolation along B: (end - start) * t
  always_comb begin
    dx = DIFF_W'(ds[NSTG-1].bex) - DIFF_W'(ds[NSTG-1].bsx);
    dy = DIFF_W'(ds[NSTG-1].bey) - DIFF_W'(ds[NSTG-1].bsy);
    tq = $signed({1'b0, ds[NSTG-1].q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= dv[NSTG-1];
    end
  end

  // Difference times ratio: DIFF_W by RATIO_BITS + 2 bits, product fits PW
  always_ff @(posedge clk) begin
    mhit  <= ds[NSTG-1].hit;
    mbsx  <= ds[NSTG-1].bsx;
    mbsy  <= ds[NSTG-1].bsy;
    prodx <= PW'(dx * tq);
    prody <= PW'(dy * tq);
  end

  // Arithmetic shift floors toward minus infinity
  always_comb begin
    shx = prodx >>> RATIO_BITS;
    shy = prody >>> RATIO_BITS;
  end

  assign out_push = mv;

  always_comb begin
    out_data.hit     = mhit;
    out_data.point_x = mhit ? coord_t'(mbsx + shx[COORD_W-1:0]) : '0;
    out_data.point_y = mhit ? coord_t'(mbsy + shy[COORD_W-1:0]) : '0;
  end

endmodule

`default_nettype wire

@@ rtl/segment_intersection_point.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Segment intersection test with fixed-point hit point.
// Input queue side: a request (two segments A and B, signed coordinates with
// 8 fraction bits) is taken on a clock edge with push high and full low.
// Result queue side: the oldest result sits on result while empty is low and
// leaves on an edge with pop high. Each request gives exactly one result:
// hit, plus the crossing point on B (zero when there is no hit).
// Throughput: one request per cycle, sustained, as long as results are popped.
// From accept to empty going low, a request passes the four front stages,
// the request queue, the RATIO_BITS + 1 stage restoring divider and the
// interpolation multiply.
// Reset (rst, synchronous) empties both queues and the pipes; full is low and
// empty is high right after it.
// When the receiver stops popping, the result queue fills, the back pipe
// stops drawing from the request queue, that queue fills and full rises; no
// request in flight is dropped.
module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     result
);

  // Result queue covers the back pipe round trip at full rate
  localparam int OUT_DEPTH = 1 << $clog2(RATIO_BITS + 5);
  localparam int MID_W     = $bits(mid_item_t);
  localparam int OUT_W     = $bits(out_item_t);

  logic      mid_push;
  logic      mid_pop;
  logic      mid_empty;
  mid_item_t mid_wdata;
  mid_item_t mid_rdata;

  logic      out_push;
  logic      out_pop;
  out_item_t out_wdata;

  // Front: differences, cross products, sign classification
  sip_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .mid_pop  (mid_pop),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  // Classified requests wait here; front credit keeps it from overflowing
  sip_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  // Back: ratio division and interpolation
  sip_back #(
    .RATIO_BITS (RATIO_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_pop   (out_pop),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  assign out_pop = pop && !empty;

  // Result queue, show-ahead
  sip_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .pop   (out_pop),
    .empty (empty),
    .rdata (result)
  );

endmodule

`default_nettype wire
